FILE: sv/tlta_pkg.sv
// ----------------------------------------------------------------------------
// tlta_pkg
// types, constants and codes shared by the track-length tally block
// ----------------------------------------------------------------------------
package tlta_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ACC_WIDTH = 48;
	localparam int WORD_WIDTH = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int DIV_WIDTH = ACC_WIDTH + FRAC_BITS;

	localparam logic [ACC_WIDTH-1:0] ACC_MAX = {ACC_WIDTH{1'b1}};
	localparam logic [WORD_WIDTH-1:0] WORD_MAX = {WORD_WIDTH{1'b1}};

	typedef enum logic [2:0] {
		OP_STEP      = 3'd0,
		OP_ENTER     = 3'd1,
		OP_NEW_TRACK = 3'd2,
		OP_COLLIDE   = 3'd3,
		OP_QUERY     = 3'd4
	} op_t;

	typedef enum logic {
		REG_IMPORTANCE = 1'b0,
		REG_MIN_SPEED  = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic [2:0]            operation;
		logic [WORD_WIDTH-1:0] step_length;
		logic [WORD_WIDTH-1:0] track_weight;
		logic [WORD_WIDTH-1:0] kinetic_energy;
		logic [WORD_WIDTH-1:0] speed;
	} in_word_t;

	typedef struct packed {
		logic [WORD_WIDTH-1:0] tracks_entering;
		logic [WORD_WIDTH-1:0] population;
		logic [WORD_WIDTH-1:0] collision_count;
		logic [47:0]           collision_weight_total;
		logic [47:0]           length_total;
		logic [47:0]           weighted_length_total;
		logic [WORD_WIDTH-1:0] number_weighted_energy;
		logic [WORD_WIDTH-1:0] flux_weighted_energy;
		logic [WORD_WIDTH-1:0] average_weight;
		logic [WORD_WIDTH-1:0] weight_times_importance;
		logic                  averages_valid;
	} out_word_t;

	// saturating accumulator add
	function automatic logic [ACC_WIDTH-1:0] acc_add(input logic [ACC_WIDTH-1:0] a,
		input logic [ACC_WIDTH-1:0] b);
		logic [ACC_WIDTH:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[ACC_WIDTH] ? ACC_MAX : s[ACC_WIDTH-1:0];
	endfunction

	function automatic logic [WORD_WIDTH-1:0] cnt_inc(input logic [WORD_WIDTH-1:0] c);
		return (c == WORD_MAX) ? c : c + 1'b1;
	endfunction

endpackage

FILE: sv/track_length_tally_accumulator.sv
// ----------------------------------------------------------------------------
// track_length_tally_accumulator
// cell tally for track-length estimation in Q16.16 fixed point
// ----------------------------------------------------------------------------
// usage:
//  - input words arrive on push/full; a word is taken when push is high and
//    full is low. a two-entry queue sits in front of the sequencer
//  - query results leave on empty/pop; the word on result is valid while
//    empty is low and is taken when pop is high
//  - step words run two multiplies then one pass of the
//    shared radix-2 divider (64 quotient bits, one per cycle)
//  - counter and collision words update their counts as they are taken
//  - a query runs three divider passes and one multiply; with a zero
//    weighted-length sum it goes straight to the report state
//  - the divider is the throughput limit for step and query words
//  - a stalled result holds the sequencer at the next query; the input
//    queue keeps filling until full rises
//  - reset clears all sums and counters, importance goes to 1.0, min_speed 1
//  - config writes are always ready; write only while idle
// ----------------------------------------------------------------------------
module track_length_tally_accumulator import tlta_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  in_word_t              item,
	output logic                  full,
	output logic                  empty,
	input  logic                  pop,
	output out_word_t             result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [WORD_WIDTH-1:0] cfg_data
);
	logic                  avail, take;
	in_word_t              head;
	logic [WORD_WIDTH-1:0] importance_q, min_speed_q;

	// config registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			importance_q <= WORD_WIDTH'(1 << FRAC_BITS);
			min_speed_q  <= WORD_WIDTH'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_IMPORTANCE: importance_q <= cfg_data;
				REG_MIN_SPEED:  min_speed_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// front end: queue of accepted words
	tlta_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .in_word(item), .full(full),
		.take(take), .avail(avail), .head(head)
	);

	// back end: arithmetic and result register
	tlta_back u_back (
		.clk(clk), .arst_n(arst_n), .avail(avail), .head(head), .take(take),
		.importance(importance_q), .min_speed(min_speed_q),
		.empty(empty), .pop(pop), .result(result)
	);
endmodule

FILE: sv/tlta_divider.sv
// ----------------------------------------------------------------------------
// tlta_divider
// restoring radix-2 divider, floor((a << FRAC_BITS) / d), one bit per cycle
// ----------------------------------------------------------------------------
module tlta_divider import tlta_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [ACC_WIDTH-1:0] dividend,
	input  logic [ACC_WIDTH-1:0] divisor,
	output logic                 done,
	output logic [DIV_WIDTH-1:0] quotient
);
	localparam int CW = $clog2(DIV_WIDTH + 1);

	logic [DIV_WIDTH-1:0] num_q;
	logic [ACC_WIDTH:0]   rem_q;
	logic [ACC_WIDTH-1:0] den_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic [ACC_WIDTH:0]   shifted;
	logic [ACC_WIDTH:0]   diff;

	assign shifted = {rem_q[ACC_WIDTH-1:0], num_q[DIV_WIDTH-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign quotient = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_WIDTH);
				num_q  <= {dividend, {FRAC_BITS{1'b0}}};
				rem_q  <= '0;
				den_q  <= divisor;
			end else if (busy_q) begin
				// quotient bits shift into num_q as dividend bits leave
				if (!diff[ACC_WIDTH]) begin
					rem_q <= diff;
					num_q <= {num_q[DIV_WIDTH-2:0], 1'b1};
				end else begin
					rem_q <= shifted;
					num_q <= {num_q[DIV_WIDTH-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
endmodule

FILE: sv/tlta_front.sv
// ----------------------------------------------------------------------------
// tlta_front
// input word queue: takes words and holds them for the back end
// ----------------------------------------------------------------------------
module tlta_front import tlta_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  in_word_t in_word,
	output logic     full,
	input  logic     take,
	output logic     avail,
	output in_word_t head
);
	localparam int PW = $clog2(QUEUE_DEPTH);

	in_word_t        mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [PW:0]     cnt_q;
	logic            do_push, do_take;

	assign full    = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign avail   = (cnt_q != '0);
	assign head    = mem_q[rd_q];
	// unused codes are dropped here
	assign do_push = push && !full && (in_word.operation <= OP_QUERY);
	assign do_take = take && avail;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= in_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_take) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(do_push) - (PW+1)'(do_take);
		end
	end
endmodule

FILE: sv/tlta_back.sv
// ----------------------------------------------------------------------------
// tlta_back
// accumulators, step arithmetic sequencer and query report
// ----------------------------------------------------------------------------
module tlta_back import tlta_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  avail,
	input  in_word_t              head,
	output logic                  take,
	input  logic [WORD_WIDTH-1:0] importance,
	input  logic [WORD_WIDTH-1:0] min_speed,
	output logic                  empty,
	input  logic                  pop,
	output out_word_t             result
);
	typedef enum logic [3:0] {
		S_IDLE, S_MUL1, S_MUL2L, S_MUL2H, S_SDIV, S_SWAIT,
		S_QDIV1, S_QWAIT1, S_QDIV2, S_QWAIT2, S_QDIV3, S_QWAIT3, S_QMUL, S_OUT
	} state_t;

	state_t                 state_q;
	in_word_t               item_q;
	logic [ACC_WIDTH-1:0]   len_sum_q, wl_sum_q, we_sum_q, eos_sum_q, cw_sum_q;
	logic [WORD_WIDTH-1:0]  enter_q, newtr_q, coll_q;
	logic [ACC_WIDTH-1:0]   slw_q, slwe_q;
	logic [WORD_WIDTH-1:0]  nwe_q, fwe_q, avw_q;
	logic                   full_q;
	logic [2*WORD_WIDTH-1:0] plo_q;

	logic                   div_start;
	logic [ACC_WIDTH-1:0]   div_a, div_d;
	logic                   div_done;
	logic [DIV_WIDTH-1:0]   div_q;

	logic [2*WORD_WIDTH-1:0] mul_p;
	logic [WORD_WIDTH-1:0]  mul_a;
	logic [WORD_WIDTH-1:0]  mul_b;
	logic [2*WORD_WIDTH-FRAC_BITS-1:0] mul_sh;
	logic [2*WORD_WIDTH:0]  hi_sum;
	logic [ACC_WIDTH-1:0]   slwe_next;
	logic [WORD_WIDTH-1:0]  mul_word;
	logic [WORD_WIDTH-1:0]  spd;
	logic [ACC_WIDTH-1:0]   div_acc;
	logic [WORD_WIDTH-1:0]  div_word;

	tlta_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a),
		.divisor(div_d), .done(div_done), .quotient(div_q)
	);

	// one shared 32x32 multiplier, operands chosen by state
	// the wide product slw * energy is built from a low and a high half
	always_comb begin
		unique case (state_q)
			S_MUL1:  begin mul_a = item_q.step_length; mul_b = item_q.track_weight; end
			S_MUL2L: begin mul_a = slw_q[WORD_WIDTH-1:0]; mul_b = item_q.kinetic_energy; end
			S_MUL2H: begin
				mul_a = WORD_WIDTH'(slw_q[ACC_WIDTH-1:WORD_WIDTH]);
				mul_b = item_q.kinetic_energy;
			end
			default: begin mul_a = avw_q; mul_b = importance; end
		endcase
	end
	assign mul_p     = mul_a * mul_b;
	assign mul_sh    = mul_p[2*WORD_WIDTH-1:FRAC_BITS];
	assign hi_sum    = {1'b0, mul_p[2*WORD_WIDTH-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}} +
		(2*WORD_WIDTH+1)'(plo_q[2*WORD_WIDTH-1:FRAC_BITS]);
	assign slwe_next = (hi_sum >> ACC_WIDTH) != '0 ? ACC_MAX : hi_sum[ACC_WIDTH-1:0];
	assign mul_word  = (mul_p >> (WORD_WIDTH + FRAC_BITS)) != '0 ? WORD_MAX :
		mul_p[WORD_WIDTH+FRAC_BITS-1:FRAC_BITS];
	assign div_acc  = (div_q >> ACC_WIDTH) != '0 ? ACC_MAX : div_q[ACC_WIDTH-1:0];
	assign div_word = (div_q >> WORD_WIDTH) != '0 ? WORD_MAX : div_q[WORD_WIDTH-1:0];
	assign spd = (item_q.speed != '0) ? item_q.speed :
		((min_speed != '0) ? min_speed : WORD_WIDTH'(1));

	always_comb begin
		div_start = 1'b0;
		div_a = slwe_q;
		div_d = ACC_WIDTH'(spd);
		unique case (state_q)
			S_SDIV:  div_start = 1'b1;
			S_QDIV1: begin div_start = 1'b1; div_a = eos_sum_q; div_d = wl_sum_q; end
			S_QDIV2: begin div_start = 1'b1; div_a = we_sum_q; div_d = wl_sum_q; end
			S_QDIV3: begin div_start = 1'b1; div_a = wl_sum_q; div_d = len_sum_q; end
			default: ;
		endcase
	end

	// only a query waits for the result register to drain
	assign take  = (state_q == S_IDLE) && avail &&
		(!full_q || (head.operation != OP_QUERY));
	assign empty = !full_q;

	always_ff @(posedge clk) begin
		if (take) item_q <= head;
		if (state_q == S_MUL1) slw_q <= mul_sh;
		if (state_q == S_MUL2L) plo_q <= mul_p;
		if (state_q == S_MUL2H) slwe_q <= slwe_next;
		if (state_q == S_QWAIT1 && div_done) nwe_q <= div_word;
		if (state_q == S_QWAIT2 && div_done) fwe_q <= div_word;
		if (state_q == S_QWAIT3 && div_done) avw_q <= div_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			full_q <= 1'b0;
			len_sum_q <= '0; wl_sum_q <= '0; we_sum_q <= '0;
			eos_sum_q <= '0; cw_sum_q <= '0;
			enter_q <= '0; newtr_q <= '0; coll_q <= '0;
		end else begin
			if (pop && full_q) full_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (take) begin
					unique case (head.operation)
						OP_STEP:      state_q <= S_MUL1;
						OP_ENTER:     enter_q <= cnt_inc(enter_q);
						OP_NEW_TRACK: newtr_q <= cnt_inc(newtr_q);
						OP_COLLIDE: begin
							coll_q <= cnt_inc(coll_q);
							cw_sum_q <= acc_add(cw_sum_q, ACC_WIDTH'(head.track_weight));
						end
						OP_QUERY:     state_q <= (wl_sum_q != '0) ? S_QDIV1 : S_OUT;
						default: ;
					endcase
				end
				S_MUL1:  state_q <= S_MUL2L;
				S_MUL2L: state_q <= S_MUL2H;
				S_MUL2H: state_q <= S_SDIV;
				S_SDIV:  state_q <= S_SWAIT;
				S_SWAIT: if (div_done) begin
					len_sum_q <= acc_add(len_sum_q, ACC_WIDTH'(item_q.step_length));
					wl_sum_q  <= acc_add(wl_sum_q, slw_q);
					we_sum_q  <= acc_add(we_sum_q, slwe_q);
					eos_sum_q <= acc_add(eos_sum_q, div_acc);
					state_q   <= S_IDLE;
				end
				S_QDIV1:  state_q <= S_QWAIT1;
				S_QWAIT1: if (div_done) state_q <= S_QDIV2;
				S_QDIV2:  state_q <= S_QWAIT2;
				S_QWAIT2: if (div_done) state_q <= S_QDIV3;
				S_QDIV3:  state_q <= S_QWAIT3;
				S_QWAIT3: if (div_done) state_q <= S_QMUL;
				S_QMUL: begin
					result.weight_times_importance <= mul_word;
					state_q <= S_OUT;
				end
				S_OUT: begin
					result.tracks_entering        <= enter_q;
					result.population             <= newtr_q;
					result.collision_count        <= coll_q;
					result.collision_weight_total <= 48'(cw_sum_q);
					result.length_total           <= 48'(len_sum_q);
					result.weighted_length_total  <= 48'(wl_sum_q);
					if (wl_sum_q != '0) begin
						result.number_weighted_energy <= nwe_q;
						result.flux_weighted_energy   <= fwe_q;
						result.average_weight         <= avw_q;
						result.averages_valid         <= 1'b1;
					end else begin
						result.number_weighted_energy  <= '0;
						result.flux_weighted_energy    <= '0;
						result.average_weight          <= '0;
						result.weight_times_importance <= '0;
						result.averages_valid          <= 1'b0;
					end
					full_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
